// File: design/lie_pkg.sv
// lie_pkg: sizes, weight table and derived widths for the loss interval estimator.
// Standalone; imported by the interfaces and the top level.
`timescale 1ns / 1ps

package lie_pkg;

  localparam int MAX_INTERVALS = 9;
  localparam int INTERVAL_BITS = 32;
  localparam int SEQ_W         = 16;
  localparam int AVG_W         = 40;
  localparam int CUR_W         = 32;
  localparam int FRAC_BITS     = 8;

  localparam int NW      = MAX_INTERVALS - 1;
  localparam int W_SCALE = NW + 2;
  localparam int W_W     = $clog2(W_SCALE + 1);

  // weight i scaled by NW+2
  function automatic int weight_of(input int i);
    int w;
    if (i < NW / 2) begin
      w = W_SCALE;
    end else begin
      w = 2 * (NW - i);
    end
    return w;
  endfunction

  function automatic int weight_sum_max();
    int s;
    s = 0;
    for (int i = 0; i < NW; i++) begin
      s = s + weight_of(i);
    end
    return s;
  endfunction

  localparam int WSUM_MAX  = weight_sum_max();
  localparam int WS_W      = $clog2(WSUM_MAX + 1);
  localparam int SUM_W     = INTERVAL_BITS + WS_W;
  localparam int NUM_W     = SUM_W + FRAC_BITS;
  localparam int DIV_STEPS = (NUM_W + 1) / 2;
  localparam int DIVN_W    = 2 * DIV_STEPS;
  localparam int DCNT_W    = $clog2(DIV_STEPS);
  localparam int IDX_W     = $clog2(MAX_INTERVALS);
  localparam int CNT_W     = $clog2(MAX_INTERVALS + 1);
  localparam int PROD_W    = INTERVAL_BITS + W_W;

  localparam logic [INTERVAL_BITS-1:0] IVL_MAX = {INTERVAL_BITS{1'b1}};

endpackage

// File: design/lie_if.sv
// lie_in_if / lie_out_if: valid/ready channels for packet beats and result beats.
// Depends on lie_pkg for field widths.
`timescale 1ns / 1ps

interface lie_in_if import lie_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [SEQ_W-1:0] seq_number;
  logic             restart;

  modport source (output valid, output seq_number, output restart, input ready);
  modport sink   (input valid, input seq_number, input restart, output ready);
endinterface

interface lie_out_if import lie_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             valid_res;
  logic [AVG_W-1:0] avg_interval;
  logic [CUR_W-1:0] current_interval;

  modport source (output valid, output valid_res, output avg_interval,
                  output current_interval, input ready);
  modport sink   (input valid, input valid_res, input avg_interval,
                  input current_interval, output ready);
endinterface

// File: design/loss_interval_estimator.sv
// loss_interval_estimator: TFRC average loss interval over a history of loss intervals.
// Depends on lie_pkg and the channel interfaces in lie_if.sv.
//
//   channel  dir  beat contents
//   in_ch    in   seq_number[15:0], restart
//   out_ch   out  valid_res, avg_interval[39:0] (8 frac bits), current_interval[31:0]
//
// One beat in, one beat out. History update on the accepting edge, then one
// shared multiply-accumulate unit runs over the k stored intervals, S_NUM forms
// the numerator and a radix-4 restoring divider forms the quotient. With no loss
// yet, MAC and divider are skipped. in_ch.ready is high only when idle.
// Synchronous active-low reset clears the history. The output register holds
// a result while out_ch stalls; the next beat is accepted meanwhile.
`timescale 1ns / 1ps

module loss_interval_estimator import lie_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lie_in_if.sink     in_ch,
  lie_out_if.source  out_ch
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MAC  = 3'd1;
  localparam logic [2:0] S_NUM  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0]               state_r;
  logic [INTERVAL_BITS-1:0] store_r [MAX_INTERVALS];
  logic [CNT_W-1:0]         count_r;
  logic [SEQ_W-1:0]         exp_r;
  logic                     loss_r;

  logic [IDX_W-1:0]         i_r;
  logic                     half_r;
  logic [SUM_W-1:0]         acc0_r, acc1_r;
  logic [WS_W-1:0]          ws_r;
  logic [DIVN_W-1:0]        num_r;
  logic [DIVN_W-1:0]        q_r;
  logic [WS_W-1:0]          rem_r;
  logic [DCNT_W-1:0]        dcnt_r;

  logic                     out_valid_r;
  logic                     out_res_r;
  logic [AVG_W-1:0]         out_avg_r;
  logic [CUR_W-1:0]         out_cur_r;

  // history update
  logic [INTERVAL_BITS-1:0] base_st [MAX_INTERVALS];
  logic [INTERVAL_BITS-1:0] store_nxt [MAX_INTERVALS];
  logic [SEQ_W-1:0]         base_exp, exp_nxt;
  logic [CNT_W-1:0]         base_cnt, count_nxt;
  logic                     base_loss, loss_nxt;
  logic                     in_order;
  logic                     in_acc;

  assign in_acc = in_ch.valid && in_ch.ready;

  always_comb begin
    base_exp  = in_ch.restart ? in_ch.seq_number : exp_r;
    base_cnt  = in_ch.restart ? CNT_W'(1) : count_r;
    base_loss = in_ch.restart ? 1'b0 : loss_r;
    for (int i = 0; i < MAX_INTERVALS; i++) begin
      base_st[i] = in_ch.restart ? '0 : store_r[i];
    end
    in_order = (in_ch.seq_number == base_exp);
    store_nxt = base_st;
    if (in_order) begin
      if (base_st[0] != IVL_MAX) begin
        store_nxt[0] = base_st[0] + INTERVAL_BITS'(1);
      end
      exp_nxt   = base_exp + SEQ_W'(1);
      count_nxt = base_cnt;
      loss_nxt  = base_loss;
    end else begin
      for (int i = 1; i < MAX_INTERVALS; i++) begin
        store_nxt[i] = base_st[i-1];
      end
      store_nxt[0] = INTERVAL_BITS'(1);
      count_nxt = (base_cnt < CNT_W'(MAX_INTERVALS)) ? base_cnt + CNT_W'(1) : base_cnt;
      exp_nxt   = in_ch.seq_number + SEQ_W'(1);
      loss_nxt  = 1'b1;
    end
  end

  // shared multiply-accumulate
  logic [IDX_W-1:0]         rd_idx;
  logic [INTERVAL_BITS-1:0] rd_val;
  logic [W_W-1:0]           w_cur;
  logic [PROD_W-1:0]        prod;
  logic                     last_mac;

  assign rd_idx   = i_r + IDX_W'(half_r);
  assign rd_val   = store_r[rd_idx];
  assign w_cur    = W_W'(weight_of(int'(i_r)));
  assign prod     = PROD_W'(rd_val) * PROD_W'(w_cur);
  assign last_mac = half_r && ((CNT_W'(i_r) + CNT_W'(2)) == count_r);

  // numerator and divider steps
  logic [SUM_W-1:0]  top;
  logic [DIVN_W-1:0] num_nxt;
  logic [WS_W:0]     t1, t2;
  logic              ge1, ge2;
  logic [WS_W-1:0]   r1, r2;

  assign top     = (acc0_r > acc1_r) ? acc0_r : acc1_r;
  assign num_nxt = DIVN_W'({top, {FRAC_BITS{1'b0}}}) + DIVN_W'(ws_r >> 1);

  always_comb begin
    t1  = {rem_r, num_r[DIVN_W-1]};
    ge1 = (t1 >= {1'b0, ws_r});
    r1  = ge1 ? WS_W'(t1 - {1'b0, ws_r}) : WS_W'(t1);
    t2  = {r1, num_r[DIVN_W-2]};
    ge2 = (t2 >= {1'b0, ws_r});
    r2  = ge2 ? WS_W'(t2 - {1'b0, ws_r}) : WS_W'(t2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= CNT_W'(1);
      exp_r       <= '0;
      loss_r      <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < MAX_INTERVALS; i++) begin
        store_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_ch.ready && state_r != S_DONE) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            store_r <= store_nxt;
            count_r <= count_nxt;
            exp_r   <= exp_nxt;
            loss_r  <= loss_nxt;
            i_r     <= '0;
            half_r  <= 1'b0;
            acc0_r  <= '0;
            acc1_r  <= '0;
            ws_r    <= '0;
            q_r     <= '0;
            state_r <= (loss_nxt && count_nxt >= CNT_W'(2)) ? S_MAC : S_DONE;
          end
        end
        S_MAC: begin
          if (!half_r) begin
            acc0_r <= acc0_r + SUM_W'(prod);
            ws_r   <= ws_r + WS_W'(w_cur);
          end else begin
            acc1_r <= acc1_r + SUM_W'(prod);
            i_r    <= i_r + IDX_W'(1);
          end
          half_r <= !half_r;
          if (last_mac) begin
            state_r <= S_NUM;
          end
        end
        S_NUM: begin
          num_r   <= num_nxt;
          rem_r   <= '0;
          dcnt_r  <= '0;
          state_r <= (ws_r == '0) ? S_DONE : S_DIV;
        end
        S_DIV: begin
          rem_r  <= r2;
          num_r  <= num_r << 2;
          q_r    <= {q_r[DIVN_W-3:0], ge1, ge2};
          dcnt_r <= dcnt_r + DCNT_W'(1);
          if (dcnt_r == DCNT_W'(DIV_STEPS - 1)) begin
            state_r <= S_DONE;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ch.ready) begin
            out_valid_r <= 1'b1;
            out_res_r   <= loss_r;
            out_avg_r   <= AVG_W'(q_r);
            out_cur_r   <= CUR_W'(store_r[0]);
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ch.ready             = (state_r == S_IDLE);
  assign out_ch.valid            = out_valid_r;
  assign out_ch.valid_res        = out_res_r;
  assign out_ch.avg_interval     = out_avg_r;
  assign out_ch.current_interval = out_cur_r;

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != S_IDLE)
    else $error("accepted beat did not start a computation");

  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r >= CNT_W'(1) && count_r <= CNT_W'(MAX_INTERVALS))
    else $error("interval count out of range");

  a_loss_count: assert property (@(posedge clk) disable iff (!rst_n)
    loss_r == (count_r != CNT_W'(1)))
    else $error("loss flag disagrees with interval count");

  a_rem_below_ws: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> rem_r < ws_r)
    else $error("divider remainder not below divisor");

  a_no_loss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.valid_res |-> out_ch.avg_interval == '0)
    else $error("average given without any loss");

endmodule

// File: verif/lie_checker.sv
// lie_checker: watches the packet and result channels of loss_interval_estimator,
// predicts each result beat from the packet history and compares field by field.
// Depends on lie_pkg and the channel interfaces in lie_if.sv.
`timescale 1ns / 1ps

module lie_checker import lie_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  lie_in_if    in_ch,
  lie_out_if   out_ch,
  output int   fail_count,
  output int   pending_results
);

  localparam int REPORT_DEPTH = 64;

  typedef struct packed {
    logic             valid_res;
    logic [AVG_W-1:0] avg_interval;
    logic [CUR_W-1:0] current_interval;
  } loss_report_t;

  logic [INTERVAL_BITS-1:0] ivl_hist [MAX_INTERVALS];
  int unsigned              ivl_count;
  logic [SEQ_W-1:0]         seq_expected;
  logic                     loss_seen;
  loss_report_t             report_buf [REPORT_DEPTH];
  int unsigned              report_wr = 0;
  int unsigned              report_rd = 0;
  int                       mismatches = 0;

  assign fail_count = mismatches;

  // TFRC weights scaled by MAX_INTERVALS+1: 1,1,1,1,.8,.6,.4,.2 for nine intervals
  function automatic int unsigned ivl_weight(input int unsigned i);
    int unsigned w;
    if (i < (MAX_INTERVALS - 1) / 2) begin
      w = MAX_INTERVALS + 1;
    end else begin
      w = 2 * (MAX_INTERVALS - 1 - i);
    end
    return w;
  endfunction

  function automatic logic [AVG_W-1:0] weighted_avg();
    logic [63:0] s_open, s_closed, w_total, num;
    s_open   = '0;
    s_closed = '0;
    w_total  = '0;
    for (int unsigned i = 0; i + 1 < ivl_count; i++) begin
      s_open   += 64'(ivl_weight(i)) * 64'(ivl_hist[i]);
      s_closed += 64'(ivl_weight(i)) * 64'(ivl_hist[i+1]);
      w_total  += 64'(ivl_weight(i));
    end
    if (w_total == 0) begin
      return '0;
    end
    num = (s_open > s_closed) ? s_open : s_closed;
    return AVG_W'((num * 256 + w_total / 2) / w_total);
  endfunction

  task automatic clear_history();
    foreach (ivl_hist[i]) begin
      ivl_hist[i] = '0;
    end
    ivl_count = 1;
    loss_seen = 1'b0;
  endtask

  task automatic track_packet(input logic [SEQ_W-1:0] seq, input logic restart,
                              output loss_report_t rpt);
    if (restart) begin
      clear_history();
      seq_expected = seq;
    end
    if (seq == seq_expected) begin
      if (ivl_hist[0] != IVL_MAX) begin
        ivl_hist[0] = ivl_hist[0] + INTERVAL_BITS'(1);
      end
      seq_expected = seq_expected + SEQ_W'(1);
    end else begin
      for (int i = MAX_INTERVALS - 1; i > 0; i--) begin
        ivl_hist[i] = ivl_hist[i-1];
      end
      ivl_hist[0] = INTERVAL_BITS'(1);
      if (ivl_count < MAX_INTERVALS) begin
        ivl_count++;
      end
      seq_expected = seq + SEQ_W'(1);
      loss_seen    = 1'b1;
    end
    rpt.valid_res        = loss_seen;
    rpt.avg_interval     = loss_seen ? weighted_avg() : '0;
    rpt.current_interval = CUR_W'(ivl_hist[0]);
  endtask

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("%0t lie_checker: %s", $time, what);
  endtask

  always @(posedge clk) begin
    loss_report_t got, want;
    if (!rst_n) begin
      clear_history();
      seq_expected = '0;
      report_wr    = 0;
      report_rd    = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        track_packet(in_ch.seq_number, in_ch.restart, want);
        report_buf[report_wr % REPORT_DEPTH] = want;
        report_wr++;
      end
      if (out_ch.valid && out_ch.ready) begin
        got.valid_res        = out_ch.valid_res;
        got.avg_interval     = out_ch.avg_interval;
        got.current_interval = out_ch.current_interval;
        if (report_wr == report_rd) begin
          report_mismatch("result beat with no packet pending");
        end else begin
          want = report_buf[report_rd % REPORT_DEPTH];
          report_rd++;
          if (got.valid_res !== want.valid_res) begin
            report_mismatch($sformatf("valid_res got %b want %b",
                                      got.valid_res, want.valid_res));
          end
          if (got.avg_interval !== want.avg_interval) begin
            report_mismatch($sformatf("avg_interval got %h want %h",
                                      got.avg_interval, want.avg_interval));
          end
          if (got.current_interval !== want.current_interval) begin
            report_mismatch($sformatf("current_interval got %h want %h",
                                      got.current_interval, want.current_interval));
          end
        end
      end
    end
    pending_results <= int'(report_wr - report_rd);
  end

endmodule

// File: verif/tb.sv
// tb: drives packet beats into loss_interval_estimator with random gaps and
// back-pressure; lie_checker predicts and compares, this module gives the verdict.
// Depends on lie_pkg, lie_if.sv, the block and verif/lie_checker.sv.
`timescale 1ns / 1ps

module tb import lie_pkg::*; ();

  localparam int RANDOM_TARGET = 825;

  // {restart, seq_number}
  localparam logic [16:0] DIRECTED_BEATS [25] = '{
    17'h00000, 17'h00001, 17'h00002, 17'h0FFFF, 17'h00000,
    17'h00001, 17'h00001, 17'h08000, 17'h08001, 17'h08002,
    17'h10005, 17'h00006, 17'h01234, 17'h01235, 17'h00000,
    17'h0AAAA, 17'h05555, 17'h0AAAB, 17'h00F0F, 17'h0F0F0,
    17'h0F0F1, 17'h03C3C, 17'h0C3C3, 17'h1FFFF, 17'h00000
  };

  logic             clk = 1'b0;
  logic             rst_n;
  int               fail_count;
  int               pending_results;
  bit               no_idle = 1'b0;
  bit               long_hold_req = 1'b0;
  logic [SEQ_W-1:0] next_seq = '0;
  int               beats_sent = 0;

  lie_in_if  in_ch();
  lie_out_if out_ch();

  always #1 clk = ~clk;

  loss_interval_estimator DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  lie_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_ch           (in_ch),
    .out_ch          (out_ch),
    .fail_count      (fail_count),
    .pending_results (pending_results)
  );

  task automatic send_packet(input logic [SEQ_W-1:0] seq, input logic restart);
    int gap;
    gap = (no_idle || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 17);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.seq_number <= seq;
    in_ch.restart    <= restart;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    next_seq = seq + SEQ_W'(1);
    beats_sent++;
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // result side: random stalls, one long hold on request
  initial begin
    int gap;
    out_ch.ready <= 1'b0;
    do @(posedge clk); while (rst_n !== 1'b1);
    forever begin
      if (long_hold_req) begin
        gap           = 300;
        long_hold_req = 1'b0;
      end else begin
        gap = (no_idle || $urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 17);
      end
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  initial begin
    int kind, run;
    bit held, paused;
    held   = 1'b0;
    paused = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.seq_number <= '0;
    in_ch.restart    <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED_BEATS[i]) begin
      send_packet(DIRECTED_BEATS[i][15:0], DIRECTED_BEATS[i][16]);
    end
    wait_drained();

    while (beats_sent < RANDOM_TARGET) begin
      no_idle = ($urandom_range(0, 4) == 0);
      if (!held && beats_sent > 250) begin
        // hold results off while packets keep coming
        held          = 1'b1;
        long_hold_req = 1'b1;
        no_idle       = 1'b1;
        repeat (20) send_packet(next_seq, 1'b0);
      end
      if (!paused && beats_sent > 500) begin
        paused = 1'b1;
        wait_drained();
      end
      kind = $urandom_range(0, 99);
      run  = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 80) : $urandom_range(0, 10);
      if (kind < 75) begin
        repeat (run) send_packet(next_seq, 1'b0);
        send_packet(next_seq + SEQ_W'($urandom_range(1, 40)), 1'b0);
      end else if (kind < 87) begin
        send_packet(SEQ_W'($urandom()), 1'b0);
      end else if (kind < 93) begin
        send_packet(next_seq - SEQ_W'($urandom_range(1, 4)), 1'b0);
      end else begin
        send_packet(SEQ_W'($urandom()), 1'b1);
        repeat (run) send_packet(next_seq, 1'b0);
      end
    end

    wait_drained();
    repeat (100) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule
